>>> rtl/core/i2c_write_only_master_serializer_core_macros.svh
// Assertion macros shared by the serializer core modules.
`ifndef I2C_WRITE_ONLY_MASTER_SERIALIZER_CORE_MACROS_SVH
`define I2C_WRITE_ONLY_MASTER_SERIALIZER_CORE_MACROS_SVH

// Checked on every rising edge of clk_i while reset is not asserted.
`define I2CWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, also during reset.
`define I2CWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/i2cwm_pkg.sv
// Shared types and constants of the write-only I2C master serializer.
`default_nettype none

package i2cwm_pkg;

  // Command codes on the input word.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Index of the last bit slot of a byte: the acknowledge slot after the eight data bits.
  localparam logic [3:0] ACK_SLOT = 4'd8;

  // Command kind after classification in the front.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  // Classified command word handed from the front to the back.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } cmd_word_t;

  // One line state as it leaves the block.
  typedef struct packed {
    logic scl;
    logic sda;
    logic drive;
    logic last;
  } line_t;

endpackage

`default_nettype wire

>>> rtl/core/i2c_write_only_master_serializer_core.sv
// A taken command is registered in the sequencer; its line states pass the result queue to the ports.
// The sequencer gives one line state per cycle while a command is sequenced and the result queue has room.
// A short command queue in the front lets the next commands be taken while one is sequenced.
// The unused command code is accepted and dropped and yields no line state.
// Reset is asynchronous and active low: queues empty, SCL level high, lines released.
`default_nettype none

module i2c_write_only_master_serializer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] cmd_i,
  input  wire logic [6:0] address_i,
  input  wire logic [7:0] data_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            scl_level_o,
  output logic            sda_level_o,
  output logic            line_drive_o,
  output logic            last_state_o
);

  logic                 cmd_valid;
  i2cwm_pkg::cmd_word_t cmd_word;
  logic                 cmd_take;
  logic                 line_room;
  logic                 line_push;
  i2cwm_pkg::line_t     line_seq;
  i2cwm_pkg::line_t     line_out;

  // Command intake and classification.
  i2cwm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .cmd_i       (cmd_i),
    .address_i   (address_i),
    .data_byte_i (data_byte_i),
    .full        (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_word),
    .cmd_take_i  (cmd_take)
  );

  // Line state sequencer.
  i2cwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_word),
    .cmd_take_o  (cmd_take),
    .line_room_i (line_room),
    .line_push_o (line_push),
    .line_o      (line_seq)
  );

  // Result buffering toward the consumer.
  i2cwm_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (line_push),
    .line_i (line_seq),
    .room_o (line_room),
    .empty  (empty),
    .pop    (pop),
    .line_o (line_out)
  );

  assign scl_level_o  = line_out.scl;
  assign sda_level_o  = line_out.sda;
  assign line_drive_o = line_out.drive;
  assign last_state_o = line_out.last;

endmodule

`default_nettype wire

>>> rtl/core/i2cwm_front.sv
// Front end: accepts command words, classifies them and queues them for the sequencer.
`default_nettype none

module i2cwm_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [6:0]           address_i,
  input  wire logic [7:0]           data_byte_i,
  output logic                      full,
  output logic                      cmd_valid_o,
  output i2cwm_pkg::cmd_word_t      cmd_o,
  input  wire logic                 cmd_take_i
);

  i2cwm_pkg::cmd_word_t word;
  logic                 keep;
  logic                 wr;
  i2cwm_pkg::cmd_word_t mem_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;

  // Classify the incoming word; the start command carries the address with a write bit.
  always_comb begin
    keep      = 1'b1;
    word.kind = i2cwm_pkg::KIND_DATA;
    word.data = data_byte_i;
    unique case (cmd_i)
      i2cwm_pkg::CMD_START: begin
        word.kind = i2cwm_pkg::KIND_START;
        word.data = {address_i, 1'b0};
      end
      i2cwm_pkg::CMD_DATA: begin
        word.kind = i2cwm_pkg::KIND_DATA;
      end
      i2cwm_pkg::CMD_STOP: begin
        word.kind = i2cwm_pkg::KIND_STOP;
      end
      default: begin
        // The unused code is accepted and dropped.
        keep = 1'b0;
      end
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign wr          = push && !full && keep;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update of the two-entry command queue.
  always_comb begin
    wr_ptr_d = wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_take_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (wr && !cmd_take_i) begin
      count_d = count_q + 2'd1;
    end else if (!wr && cmd_take_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= word;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/i2cwm_back.sv
// Back end: sequencer that turns one queued command into its line states.
`default_nettype none

`include "i2c_write_only_master_serializer_core_macros.svh"

module i2cwm_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  wire i2cwm_pkg::cmd_word_t cmd_i,
  output logic                      cmd_take_o,
  input  wire logic                 line_room_i,
  output logic                      line_push_o,
  output i2cwm_pkg::line_t          line_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PRE  = 4'b0010,
    ST_BYTE = 4'b0100,
    ST_STOP = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] sub_q, sub_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       clk_lvl_q, clk_lvl_d;
  logic       drv_q, drv_d;
  logic       emit;
  logic       done;

  assign emit        = (state_q != ST_IDLE) && line_room_i;
  assign done        = emit && line_o.last;
  assign cmd_take_o  = cmd_valid_i && ((state_q == ST_IDLE) || done);
  assign line_push_o = emit;

  // Line state of the current step.
  always_comb begin
    line_o.scl   = 1'b1;
    line_o.sda   = 1'b1;
    line_o.drive = drv_q;
    line_o.last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        line_o.scl = clk_lvl_q;
      end
      ST_PRE: begin
        // Both lines high, then SDA low, then SCL low.
        line_o.scl = (sub_q != 2'd2);
        line_o.sda = (sub_q == 2'd0);
      end
      ST_BYTE: begin
        line_o.scl  = (sub_q == 2'd1);
        line_o.sda  = (bit_q == i2cwm_pkg::ACK_SLOT) ? 1'b0 : shift_q[7];
        line_o.last = (bit_q == i2cwm_pkg::ACK_SLOT) && (sub_q == 2'd2);
      end
      ST_STOP: begin
        // SDA low with SCL held, SCL high, SDA high, then release.
        line_o.scl   = (sub_q == 2'd0) ? clk_lvl_q : 1'b1;
        line_o.sda   = (sub_q == 2'd2) || (sub_q == 2'd3);
        line_o.drive = (sub_q == 2'd3) ? 1'b0 : drv_q;
        line_o.last  = (sub_q == 2'd3);
      end
      default: begin
        line_o.scl = clk_lvl_q;
      end
    endcase
  end

  // Step sequencing and loading of the next command.
  always_comb begin
    state_d   = state_q;
    sub_d     = sub_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    clk_lvl_d = emit ? line_o.scl : clk_lvl_q;
    drv_d     = drv_q;

    if (emit) begin
      unique case (state_q)
        ST_PRE: begin
          if (sub_q == 2'd2) begin
            state_d = ST_BYTE;
            sub_d   = 2'd0;
            bit_d   = 4'd0;
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
        ST_BYTE: begin
          if (sub_q == 2'd2) begin
            sub_d = 2'd0;
            if (bit_q == i2cwm_pkg::ACK_SLOT) begin
              state_d = ST_IDLE;
            end else begin
              bit_d   = bit_q + 4'd1;
              shift_d = {shift_q[6:0], 1'b0};
            end
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
        ST_STOP: begin
          if (sub_q == 2'd3) begin
            state_d = ST_IDLE;
            drv_d   = 1'b0;
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end

    if (cmd_take_o) begin
      sub_d   = 2'd0;
      bit_d   = 4'd0;
      shift_d = cmd_i.data;
      unique case (cmd_i.kind)
        i2cwm_pkg::KIND_START: begin
          state_d = ST_PRE;
          drv_d   = 1'b1;
        end
        i2cwm_pkg::KIND_DATA: begin
          state_d = ST_BYTE;
        end
        i2cwm_pkg::KIND_STOP: begin
          state_d = ST_STOP;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sub_q     <= 2'd0;
      bit_q     <= 4'd0;
      clk_lvl_q <= 1'b1;
      drv_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      sub_q     <= sub_d;
      bit_q     <= bit_d;
      clk_lvl_q <= clk_lvl_d;
      drv_q     <= drv_d;
    end
  end

  // The shift register is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  // A command is only taken when the front offers one.
  `I2CWM_ASSERT(take_needs_valid_a, cmd_take_o |-> cmd_valid_i, "command taken from empty queue")
  // The bit slot never runs past the acknowledge slot.
  `I2CWM_ASSERT(bit_in_range_a, (state_q == ST_BYTE) |-> (bit_q <= i2cwm_pkg::ACK_SLOT),
                "bit slot out of range")
  // The start preamble always drives the lines.
  `I2CWM_ASSERT(pre_drives_a, (emit && (state_q == ST_PRE)) |-> line_o.drive,
                "start preamble with released lines")

endmodule

`default_nettype wire

>>> rtl/core/i2cwm_outq.sv
// Result queue: two-entry buffer between the sequencer and the result ports.
`default_nettype none

`include "i2c_write_only_master_serializer_core_macros.svh"

module i2cwm_outq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire i2cwm_pkg::line_t     line_i,
  output logic                      room_o,
  output logic                      empty,
  input  wire logic                 pop,
  output i2cwm_pkg::line_t          line_o
);

  i2cwm_pkg::line_t mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             rd;

  assign room_o = (count_q != 2'd2);
  assign empty  = (count_q == 2'd0);
  assign rd     = pop && !empty;
  assign line_o = mem_q[rd_ptr_q];

  // Fill count follows the write and read words.
  always_comb begin
    count_d = count_q;
    if (push_i && !rd) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && rd) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= line_i;
    end
  end

  // The sequencer never writes a full queue.
  `I2CWM_ASSERT(no_overflow_a, push_i |-> room_o, "result queue overflow")
  // The fill count stays within the queue depth.
  `I2CWM_ASSERT_ALWAYS(count_range_a, count_q <= 2'd2, "result queue count out of range")

endmodule

`default_nettype wire
